>>> hw/rtl/lcs_pkg.sv
// Shared types and constants of the linear congruence solver.
package lcs_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int STATUS_W      = 2;

  localparam logic [STATUS_W-1:0] STATUS_SOLVED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOSOL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_GCD_AB,
    OP_GCD_N,
    OP_DIV_R,
    OP_DIV_SEL,
    OP_DIV_AN,
    OP_DIV_BN,
    OP_DIV_STEP,
    OP_GCD_ADV,
    OP_QSTORE,
    OP_EE_INIT,
    OP_EE_ADV,
    OP_MUL_STEP,
    OP_EE_T,
    OP_FIN_MUL,
    OP_OUT_INVALID,
    OP_OUT_NOSOL,
    OP_OUT_SOLVED
  } op_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_N
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic r1_zero;
    logic r0_one;
    logic my_zero;
    logic out_free;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_G_TEST,
    S_G_DIV,
    S_G_ADV,
    S_Q_START,
    S_Q_STORE,
    S_EE_INIT,
    S_E_TEST,
    S_E_ADV,
    S_E_T,
    S_FIN_MUL,
    S_DIV,
    S_MUL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_G1,
    PH_G2,
    PH_G3
  } phase_t;

endpackage

>>> hw/rtl/linear_congruence_solver_core.sv
// Top level of the linear congruence solver: controller and datapath.
//
// Solves coef_a * x = rhs_b (mod modulus_n) for unsigned WIDTH-bit values.
// Input channel (s_*): one word carries coef_a, rhs_b and modulus_n; it is
// accepted when s_tvalid and s_tready are both high. Output channel (m_*):
// one word per input carries status, solution, reduced_modulus and inverse.
// The block works on one word at a time; s_tready is low from the cycle after
// an accept until the block is idle again. Every division runs on the one
// shared bit-serial divider. Each step of the three gcd loops is one
// division, six divisions are fixed (five scalings and a mod n), a solved
// word adds b mod n, and each extended Euclid step and the final product add
// a modular multiply. The latency is data dependent. Invalid input (a or n
// zero) goes from the check straight to the result. The result sits in an
// output register, so a new word is accepted in the cycle after a result
// is written, even while it still waits; a stalled receiver holds the result
// stable, and the block finishes its next item and then waits for the
// register to free up. Synchronous reset clears the controller and
// drops m_tvalid; no result is pending after reset.
module linear_congruence_solver_core #(
  parameter int WIDTH = lcs_pkg::DEFAULT_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // coef_a, rhs_b, modulus_n from bit 0 up, zero padded to whole bytes.
  input  logic [((3*WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status, solution, reduced_modulus, inverse from bit 0 up, zero padded.
  output logic [((3*WIDTH+lcs_pkg::STATUS_W+7)/8)*8-1:0] m_tdata
);

  localparam int IN_W    = 3 * WIDTH;
  localparam int OUT_W   = lcs_pkg::STATUS_W + 3 * WIDTH;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8 - OUT_W;

  lcs_pkg::cmd_t   cmd;
  lcs_pkg::stat_t  stat;
  logic [OUT_W-1:0] out_data;

  lcs_controller #(.WIDTH(WIDTH)) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcs_datapath #(.WIDTH(WIDTH), .IN_W(IN_W), .OUT_W(OUT_W)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata[IN_W-1:0]),
    .out_data  (out_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  generate
    if (OUT_PAD > 0) begin : g_pad
      assign m_tdata = {{OUT_PAD{1'b0}}, out_data};
    end else begin : g_nopad
      assign m_tdata = out_data;
    end
  endgenerate

endmodule

>>> hw/rtl/lcs_datapath.sv
// Datapath of the solver: working registers, bit-serial divider, modular multiplier, result word.
module lcs_datapath #(
  parameter int WIDTH = lcs_pkg::DEFAULT_WIDTH,
  parameter int IN_W  = 3 * WIDTH,
  parameter int OUT_W = lcs_pkg::STATUS_W + 3 * WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  lcs_pkg::cmd_t       cmd,
  output lcs_pkg::stat_t      stat,
  input  logic [IN_W-1:0]     in_data,
  output logic [OUT_W-1:0]    out_data,
  output logic                out_valid,
  input  logic                out_ready
);

  logic [WIDTH-1:0] ra, rb, rn, r0, r1, t0, t1;
  logic [WIDTH-1:0] dd, rem, dv;
  logic [WIDTH-1:0] mx, my, acc;
  logic [WIDTH:0]   rem_w;
  logic             q_bit;
  logic [WIDTH-1:0] sel_val, acc_add, mx_dbl, q_red, t_sub;

  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH-1:0] gap;
    gap = m - y;
    return (x >= gap) ? (x - gap) : (x + y);
  endfunction

  always_comb begin
    rem_w   = {rem, dd[WIDTH-1]};
    q_bit   = (rem_w >= {1'b0, dv});
    acc_add = add_mod(acc, mx, rn);
    mx_dbl  = add_mod(mx, mx, rn);
    q_red   = (dd >= rn) ? (dd - rn) : dd;
    t_sub   = (t0 >= acc) ? (t0 - acc) : (t0 + (rn - acc));
    case (cmd.sel)
      lcs_pkg::SEL_A: sel_val = ra;
      lcs_pkg::SEL_B: sel_val = rb;
      default:        sel_val = rn;
    endcase
  end

  assign stat.invalid  = (ra == '0) || (rn == '0);
  assign stat.r1_zero  = (r1 == '0);
  assign stat.r0_one   = (r0 == WIDTH'(1));
  assign stat.my_zero  = (my == '0);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      lcs_pkg::OP_LOAD: begin
        ra <= in_data[0 +: WIDTH];
        rb <= in_data[WIDTH +: WIDTH];
        rn <= in_data[2*WIDTH +: WIDTH];
      end
      lcs_pkg::OP_GCD_AB: begin
        r0 <= ra;
        r1 <= rb;
      end
      lcs_pkg::OP_GCD_N: r1 <= rn;
      lcs_pkg::OP_DIV_R: begin
        dd <= r0; dv <= r1; rem <= '0;
      end
      lcs_pkg::OP_DIV_SEL: begin
        dd <= sel_val; dv <= r0; rem <= '0;
      end
      lcs_pkg::OP_DIV_AN: begin
        dd <= ra; dv <= rn; rem <= '0;
      end
      lcs_pkg::OP_DIV_BN: begin
        dd <= rb; dv <= rn; rem <= '0;
      end
      lcs_pkg::OP_DIV_STEP: begin
        rem <= q_bit ? WIDTH'(rem_w - {1'b0, dv}) : rem_w[WIDTH-1:0];
        dd  <= {dd[WIDTH-2:0], q_bit};
      end
      lcs_pkg::OP_GCD_ADV: begin
        r0 <= r1;
        r1 <= rem;
      end
      lcs_pkg::OP_QSTORE: begin
        case (cmd.sel)
          lcs_pkg::SEL_A: ra <= dd;
          lcs_pkg::SEL_B: rb <= dd;
          default: begin
            // The reduced a and b are already stored, so their gcd starts here.
            rn <= dd;
            r0 <= ra;
            r1 <= rb;
          end
        endcase
      end
      lcs_pkg::OP_EE_INIT: begin
        r0 <= rn;
        r1 <= rem;
        t0 <= '0;
        t1 <= (rn > WIDTH'(1)) ? WIDTH'(1) : '0;
      end
      lcs_pkg::OP_EE_ADV: begin
        r0  <= r1;
        r1  <= rem;
        mx  <= q_red;
        my  <= t1;
        acc <= '0;
      end
      lcs_pkg::OP_MUL_STEP: begin
        if (my[0]) begin
          acc <= acc_add;
        end
        mx <= mx_dbl;
        my <= my >> 1;
      end
      lcs_pkg::OP_EE_T: begin
        t0 <= t1;
        t1 <= t_sub;
      end
      lcs_pkg::OP_FIN_MUL: begin
        mx  <= t0;
        my  <= rem;
        acc <= '0;
      end
      default: ;
    endcase
  end

  // Result word and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        lcs_pkg::OP_OUT_INVALID: begin
          out_valid <= 1'b1;
          out_data  <= {{(3*WIDTH){1'b0}}, lcs_pkg::STATUS_INVALID};
        end
        lcs_pkg::OP_OUT_NOSOL: begin
          out_valid <= 1'b1;
          out_data  <= {{WIDTH{1'b0}}, rn, {WIDTH{1'b0}}, lcs_pkg::STATUS_NOSOL};
        end
        lcs_pkg::OP_OUT_SOLVED: begin
          out_valid <= 1'b1;
          out_data  <= {t0, rn, acc, lcs_pkg::STATUS_SOLVED};
        end
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/lcs_controller.sv
// Sequencing state machine of the solver.
module lcs_controller #(
  parameter int WIDTH = lcs_pkg::DEFAULT_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lcs_pkg::stat_t stat,
  output lcs_pkg::cmd_t  cmd
);

  localparam int CNT_W = $clog2(WIDTH);

  lcs_pkg::state_t state, state_next, ret, ret_next;
  lcs_pkg::phase_t phase, phase_next;
  lcs_pkg::sel_t   sel, sel_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             div_last;
  lcs_pkg::cmd_t    cmd_seq;

  assign div_last = (cnt == CNT_W'(WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcs_pkg::S_IDLE;
      ret   <= lcs_pkg::S_IDLE;
      phase <= lcs_pkg::PH_G1;
      sel   <= lcs_pkg::SEL_A;
      cnt   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      phase <= phase_next;
      sel   <= sel_next;
      cnt   <= cnt_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    phase_next = phase;
    sel_next   = sel;
    cnt_next   = cnt;
    case (state)
      lcs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = lcs_pkg::S_CHECK;
        end
      end
      lcs_pkg::S_CHECK: begin
        if (stat.invalid) begin
          state_next = lcs_pkg::S_DONE;
        end else begin
          phase_next = lcs_pkg::PH_G1;
          state_next = lcs_pkg::S_G_TEST;
        end
      end
      lcs_pkg::S_G_TEST: begin
        if (!stat.r1_zero) begin
          ret_next   = lcs_pkg::S_G_ADV;
          state_next = lcs_pkg::S_DIV;
        end else begin
          case (phase)
            lcs_pkg::PH_G1: begin
              phase_next = lcs_pkg::PH_G2;
              state_next = lcs_pkg::S_G_TEST;
            end
            default: begin
              sel_next   = lcs_pkg::SEL_A;
              state_next = lcs_pkg::S_Q_START;
            end
          endcase
        end
      end
      lcs_pkg::S_G_ADV:   state_next = lcs_pkg::S_G_TEST;
      lcs_pkg::S_Q_START: begin
        ret_next   = lcs_pkg::S_Q_STORE;
        state_next = lcs_pkg::S_DIV;
      end
      lcs_pkg::S_Q_STORE: begin
        if (sel == lcs_pkg::SEL_A) begin
          sel_next   = lcs_pkg::SEL_B;
          state_next = lcs_pkg::S_Q_START;
        end else if (sel == lcs_pkg::SEL_B && phase == lcs_pkg::PH_G2) begin
          sel_next   = lcs_pkg::SEL_N;
          state_next = lcs_pkg::S_Q_START;
        end else if (phase == lcs_pkg::PH_G2) begin
          phase_next = lcs_pkg::PH_G3;
          state_next = lcs_pkg::S_G_TEST;
        end else begin
          state_next = lcs_pkg::S_EE_INIT;
        end
      end
      lcs_pkg::S_EE_INIT: begin
        // First pass runs the divide of a by n, the second seeds the loop.
        if (ret == lcs_pkg::S_EE_INIT) begin
          state_next = lcs_pkg::S_E_TEST;
        end else begin
          ret_next   = lcs_pkg::S_EE_INIT;
          state_next = lcs_pkg::S_DIV;
        end
      end
      lcs_pkg::S_E_TEST: begin
        if (!stat.r1_zero) begin
          ret_next   = lcs_pkg::S_E_ADV;
          state_next = lcs_pkg::S_DIV;
        end else if (stat.r0_one) begin
          ret_next   = lcs_pkg::S_FIN_MUL;
          state_next = lcs_pkg::S_DIV;
        end else begin
          state_next = lcs_pkg::S_DONE;
        end
      end
      lcs_pkg::S_E_ADV: begin
        ret_next   = lcs_pkg::S_E_T;
        state_next = lcs_pkg::S_MUL;
      end
      lcs_pkg::S_E_T: state_next = lcs_pkg::S_E_TEST;
      lcs_pkg::S_FIN_MUL: begin
        ret_next   = lcs_pkg::S_DONE;
        state_next = lcs_pkg::S_MUL;
      end
      lcs_pkg::S_DIV: begin
        if (div_last) begin
          cnt_next   = '0;
          state_next = ret;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      lcs_pkg::S_MUL: begin
        if (stat.my_zero) begin
          state_next = ret;
        end
      end
      lcs_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_next = lcs_pkg::S_IDLE;
        end
      end
      default: state_next = lcs_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready    = 1'b0;
    cmd_seq.op  = lcs_pkg::OP_NONE;
    cmd_seq.sel = sel;
    case (state)
      lcs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_seq.op = lcs_pkg::OP_LOAD;
        end
      end
      lcs_pkg::S_CHECK: begin
        if (!stat.invalid) begin
          cmd_seq.op = lcs_pkg::OP_GCD_AB;
        end
      end
      lcs_pkg::S_G_TEST: begin
        if (!stat.r1_zero) begin
          cmd_seq.op = lcs_pkg::OP_DIV_R;
        end else if (phase == lcs_pkg::PH_G1) begin
          cmd_seq.op = lcs_pkg::OP_GCD_N;
        end
      end
      lcs_pkg::S_G_ADV:   cmd_seq.op = lcs_pkg::OP_GCD_ADV;
      lcs_pkg::S_Q_START: cmd_seq.op = lcs_pkg::OP_DIV_SEL;
      lcs_pkg::S_Q_STORE: begin
        cmd_seq.op = lcs_pkg::OP_QSTORE;
      end
      lcs_pkg::S_EE_INIT: cmd_seq.op = lcs_pkg::OP_NONE;
      lcs_pkg::S_E_TEST: begin
        if (!stat.r1_zero) begin
          cmd_seq.op = lcs_pkg::OP_DIV_R;
        end else if (stat.r0_one) begin
          cmd_seq.op = lcs_pkg::OP_DIV_BN;
        end
      end
      lcs_pkg::S_E_ADV:   cmd_seq.op = lcs_pkg::OP_EE_ADV;
      lcs_pkg::S_E_T:     cmd_seq.op = lcs_pkg::OP_EE_T;
      lcs_pkg::S_FIN_MUL: cmd_seq.op = lcs_pkg::OP_FIN_MUL;
      lcs_pkg::S_DIV:     cmd_seq.op = lcs_pkg::OP_DIV_STEP;
      lcs_pkg::S_MUL: begin
        if (!stat.my_zero) begin
          cmd_seq.op = lcs_pkg::OP_MUL_STEP;
        end
      end
      lcs_pkg::S_DONE: begin
        if (stat.out_free) begin
          if (stat.invalid) begin
            cmd_seq.op = lcs_pkg::OP_OUT_INVALID;
          end else if (ret == lcs_pkg::S_DONE) begin
            cmd_seq.op = lcs_pkg::OP_OUT_SOLVED;
          end else begin
            cmd_seq.op = lcs_pkg::OP_OUT_NOSOL;
          end
        end
      end
      default: cmd_seq.op = lcs_pkg::OP_NONE;
    endcase
    // In the third phase the store of the reduced b also issues the quotient store.
    if (state == lcs_pkg::S_Q_STORE && sel != lcs_pkg::SEL_A &&
        phase == lcs_pkg::PH_G3) begin
      cmd_seq.op = lcs_pkg::OP_QSTORE;
    end
  end

  lcs_initdiv u_init (
    .state   (state),
    .ret     (ret),
    .cmd_in  (cmd_seq),
    .cmd_out (cmd)
  );

endmodule

>>> hw/rtl/lcs_initdiv.sv
// Step that forms a mod n and seeds the extended Euclid registers.
module lcs_initdiv (
  input  lcs_pkg::state_t state,
  input  lcs_pkg::state_t ret,
  input  lcs_pkg::cmd_t   cmd_in,
  output lcs_pkg::cmd_t   cmd_out
);

  // Entering the init step first runs a divide of a by n, then seeds the
  // Euclid registers when that divide returns.
  always_comb begin
    cmd_out = cmd_in;
    if (state == lcs_pkg::S_EE_INIT) begin
      cmd_out.op = (ret == lcs_pkg::S_EE_INIT) ? lcs_pkg::OP_EE_INIT
                                               : lcs_pkg::OP_DIV_AN;
    end
  end

endmodule

>>> hw/rtl/lcs_checker.sv
// Port-level checks of the solver, bound to the top level.
module lcs_checker #(
  parameter int WIDTH = lcs_pkg::DEFAULT_WIDTH
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((3*WIDTH+lcs_pkg::STATUS_W+7)/8)*8-1:0] m_tdata
);

  localparam int SW = lcs_pkg::STATUS_W;

  logic [SW-1:0]    st;
  logic [WIDTH-1:0] sol, red, inv;

  assign st  = m_tdata[SW-1:0];
  assign sol = m_tdata[SW +: WIDTH];
  assign red = m_tdata[SW+WIDTH +: WIDTH];
  assign inv = m_tdata[SW+2*WIDTH +: WIDTH];

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (st == lcs_pkg::STATUS_SOLVED || st == lcs_pkg::STATUS_NOSOL ||
                  st == lcs_pkg::STATUS_INVALID))
    else $error("unknown status code");

  a_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == lcs_pkg::STATUS_INVALID |-> sol == '0 && red == '0 && inv == '0)
    else $error("invalid result carries data");

  a_solved: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == lcs_pkg::STATUS_SOLVED |-> red != '0 && sol < red && inv < red)
    else $error("solution not reduced");

endmodule

bind linear_congruence_solver_core lcs_checker #(.WIDTH(WIDTH)) u_lcs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> test/tb_linear_congruence_solver_core.sv
// Self-checking testbench of the linear congruence solver core.
module tb_linear_congruence_solver_core;

  localparam int WIDTH = 32;
  localparam int ST_W = lcs_pkg::STATUS_W;
  localparam int SW = ((3*WIDTH+7)/8)*8;
  localparam int MW = ((3*WIDTH+ST_W+7)/8)*8;
  localparam int N_RANDOM = 730;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [WIDTH-1:0] solution;
    logic [WIDTH-1:0] reduced_modulus;
    logic [WIDTH-1:0] inverse;
  } answer_t;

  typedef struct {
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] n;
    logic known;
    answer_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MW-1:0] m_tdata;

  answer_t expected_answers[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit long_stall = 1'b0;

  linear_congruence_solver_core #(.WIDTH(WIDTH)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != '0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Expected answer of the congruence a*x = b (mod n).
  function automatic answer_t solve_congruence(logic [WIDTH-1:0] ai, logic [WIDTH-1:0] bi,
                                               logic [WIDTH-1:0] ni);
    answer_t r;
    logic [63:0] a, b, n, g, r0, r1, r2, t0, t1, t2, q, qt;
    r = '0;
    a = 64'(ai); b = 64'(bi); n = 64'(ni);
    if (a == '0 || n == '0) begin
      r.status = lcs_pkg::STATUS_INVALID;
      return r;
    end
    g = gcd64(gcd64(a, b), n);
    a = a / g; b = b / g; n = n / g;
    g = gcd64(a, b);
    a = a / g; b = b / g;
    r.reduced_modulus = n[WIDTH-1:0];
    r0 = n; r1 = a % n; t0 = '0; t1 = (n > 64'd1) ? 64'd1 : 64'd0;
    while (r1 != '0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      qt = 64'((128'(q % n) * 128'(t1)) % 128'(n));
      t2 = (t0 >= qt) ? t0 - qt : t0 + (n - qt);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    if (r0 != 64'd1) begin
      r.status = lcs_pkg::STATUS_NOSOL;
      return r;
    end
    r.status = lcs_pkg::STATUS_SOLVED;
    r.inverse = t0[WIDTH-1:0];
    r.solution = WIDTH'((128'(t0) * 128'(b % n)) % 128'(n));
    return r;
  endfunction

  // Directed rows: extremes, invalid input, no solution, modulus one.
  row_t rows[] = '{
    '{32'd0, 32'd5, 32'd7, 1'b1, '{lcs_pkg::STATUS_INVALID, 32'd0, 32'd0, 32'd0}},
    '{32'd3, 32'd5, 32'd0, 1'b1, '{lcs_pkg::STATUS_INVALID, 32'd0, 32'd0, 32'd0}},
    '{32'd0, 32'd0, 32'd0, 1'b1, '{lcs_pkg::STATUS_INVALID, 32'd0, 32'd0, 32'd0}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 1'b1,
      '{lcs_pkg::STATUS_INVALID, 32'd0, 32'd0, 32'd0}},
    '{32'd1, 32'd0, 32'd1, 1'b1, '{lcs_pkg::STATUS_SOLVED, 32'd0, 32'd1, 32'd0}},
    '{32'd2, 32'd1, 32'd4, 1'b1, '{lcs_pkg::STATUS_NOSOL, 32'd0, 32'd4, 32'd0}},
    '{32'd3, 32'd2, 32'd7, 1'b0, '0},
    '{32'd6, 32'd4, 32'd10, 1'b0, '0},
    '{32'd4, 32'd6, 32'd8, 1'b0, '0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{32'hFFFFFFFF, 32'd1, 32'hFFFFFFFE, 1'b0, '0},
    '{32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFB, 1'b0, '0},
    '{32'h55555555, 32'hAAAAAAAA, 32'h80000000, 1'b0, '0},
    '{32'd5, 32'd0, 32'd9, 1'b0, '0},
    '{32'hB504F333, 32'h9E3779B9, 32'hFFFFFFF1, 1'b0, '0},
    '{32'd12, 32'd18, 32'd30, 1'b0, '0},
    '{32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0}
  };

  // Offers one word; the caller drops s_tvalid after the last one.
  task automatic send_word(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b, logic [WIDTH-1:0] n,
                           logic known, answer_t ans);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= SW'({n, b, a});
    expected_answers = {expected_answers, known ? ans : solve_congruence(a, b, n)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [WIDTH-1:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 40);
      1: return $urandom;
      2: return $urandom >> $urandom_range(0, 31);
      default: return ~($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    logic [WIDTH-1:0] a, b, n, f;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_word(rows[i].a, rows[i].b, rows[i].n, rows[i].known, rows[i].ans);
    for (int i = 0; i < N_RANDOM; i++) begin
      a = rand_val(); b = rand_val(); n = rand_val();
      // Mostly valid input; some share a factor to exercise the reductions.
      if ($urandom_range(0, 9) != 0 && n == 0) n = $urandom | 1;
      if ($urandom_range(0, 9) != 0 && a == 0) a = $urandom_range(1, 1000);
      if ($urandom_range(0, 3) == 0) begin
        f = $urandom_range(2, 12);
        a = a * f; n = n * f;
        if ($urandom_range(0, 1)) b = b * f;
      end
      if (i == 40) long_stall = 1'b1;
      send_word(a, b, n, 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random hold-off per word, with one long stall to back up the block.
  initial begin
    int wait_cycles;
    @(negedge clk);
    forever begin
      if (long_stall) begin
        long_stall = 1'b0;
        m_tready <= 1'b0;
        repeat (20000) @(negedge clk);
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (wait_cycles != 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    answer_t got, exp_ans;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[ST_W-1:0], m_tdata[ST_W+WIDTH-1:ST_W],
              m_tdata[ST_W+2*WIDTH-1:ST_W+WIDTH],
              m_tdata[ST_W+3*WIDTH-1:ST_W+2*WIDTH]};
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected word status=%0d solution=%0d", $time, got.status,
                 got.solution);
        errors++;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (got.status !== exp_ans.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.status, got.status);
          errors++;
        end
        if (got.solution !== exp_ans.solution) begin
          $display("%0t: solution expected %0d actual %0d", $time, exp_ans.solution,
                   got.solution);
          errors++;
        end
        if (got.reduced_modulus !== exp_ans.reduced_modulus) begin
          $display("%0t: reduced_modulus expected %0d actual %0d", $time,
                   exp_ans.reduced_modulus, got.reduced_modulus);
          errors++;
        end
        if (got.inverse !== exp_ans.inverse) begin
          $display("%0t: inverse expected %0d actual %0d", $time, exp_ans.inverse,
                   got.inverse);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #400000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
